// ----- hdl/sbp_pkg.sv -----
// package: field codes, status codes, result type and status lookup for the SCT byte parser
`default_nettype none

package sbp_pkg;

  // default length of the log id field in bytes
  localparam int unsigned LOG_ID_BYTES_DEF = 32;

  // fixed field lengths in bytes
  localparam logic [15:0] LEN_VERSION = 16'd1;
  localparam logic [15:0] LEN_TIME    = 16'd8;
  localparam logic [15:0] LEN_EXTLEN  = 16'd2;
  localparam logic [15:0] LEN_HASH    = 16'd1;
  localparam logic [15:0] LEN_SIGALG  = 16'd1;
  localparam logic [15:0] LEN_SIGLEN  = 16'd2;

  localparam logic [15:0] OFFSET_MAX = 16'hFFFF;

  // field the current byte belongs to
  typedef enum logic [3:0] {
    PH_VERSION = 4'd0,
    PH_LOGID   = 4'd1,
    PH_TIME    = 4'd2,
    PH_EXTLEN  = 4'd3,
    PH_EXT     = 4'd4,
    PH_HASH    = 4'd5,
    PH_SIGALG  = 4'd6,
    PH_SIGLEN  = 4'd7,
    PH_SIG     = 4'd8,
    PH_TRAIL   = 4'd9
  } sbp_phase_e;

  // status reported with the closing byte
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_HDR_SHORT   = 3'd1,
    ST_NO_EXTLEN   = 3'd2,
    ST_EXT_OVERRUN = 3'd3,
    ST_NO_SIGHDR   = 3'd4,
    ST_SIG_OVERRUN = 3'd5
  } sbp_status_e;

  // one tagged byte with the decoded fields so far
  typedef struct packed {
    sbp_phase_e  field_kind;
    logic [7:0]  byte_out;
    logic [15:0] field_offset;
    logic        record_done;
    sbp_status_e parse_status;
    logic [7:0]  version_value;
    logic [63:0] timestamp_value;
    logic [15:0] ext_length_value;
    logic [7:0]  hash_alg_value;
    logic [7:0]  sig_alg_value;
    logic [15:0] sig_length_value;
  } sbp_result_t;

  // status from the field the parser would need next
  function automatic sbp_status_e status_for_next(input sbp_phase_e next_phase);
    sbp_status_e st;
    unique case (next_phase)
      PH_VERSION, PH_LOGID, PH_TIME: st = ST_HDR_SHORT;
      PH_EXTLEN:                     st = ST_NO_EXTLEN;
      PH_EXT:                        st = ST_EXT_OVERRUN;
      PH_HASH, PH_SIGALG, PH_SIGLEN: st = ST_NO_SIGHDR;
      PH_SIG:                        st = ST_SIG_OVERRUN;
      default:                       st = ST_OK;
    endcase
    return st;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sct_byte_stream_parser_core.sv -----
// top level of the SCT byte stream parser: field tracker and result register
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+---------------------------------------
//   input   | in        | in_valid_i/in_stall_o | data_byte_i, item_last_i
//   result  | out       | out_valid_o/out_stall_i | field kind, byte, offset, status, fields
//
// One byte per clock while the result side does not stall: a byte accepted at an edge
// has its result on the ports in the following cycle, straight out of the result register.
// Parser state updates in the same cycle as the accept, so throughput is one byte per cycle when not stalled.
// Reset returns the parser to the version field with all decoded fields zero.
// While a held result is stalled, the input side is stalled too.
`default_nettype none

module sct_byte_stream_parser_core
  import sbp_pkg::*;
#(
  parameter int unsigned LogIdBytes = LOG_ID_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        item_last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [3:0]       field_kind_o,
  output logic [7:0]       byte_out_o,
  output logic [15:0]      field_offset_o,
  output logic             record_done_o,
  output logic [2:0]       parse_status_o,
  output logic [7:0]       version_value_o,
  output logic [63:0]      timestamp_value_o,
  output logic [15:0]      ext_length_value_o,
  output logic [7:0]       hash_alg_value_o,
  output logic [7:0]       sig_alg_value_o,
  output logic [15:0]      sig_length_value_o
);

  logic        accept;
  sbp_result_t cur_result;
  sbp_result_t held_result;

  assign accept = in_valid_i && !in_stall_o;

  // per-byte field tracking
  sbp_field_tracker #(
    .LogIdBytes (LogIdBytes)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .item_last_i (item_last_i),
    .result_o    (cur_result)
  );

  // result register
  sbp_out_stage u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_result_i  (cur_result),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_result_o (held_result)
  );

  // unpack to ports
  assign field_kind_o       = held_result.field_kind;
  assign byte_out_o         = held_result.byte_out;
  assign field_offset_o     = held_result.field_offset;
  assign record_done_o      = held_result.record_done;
  assign parse_status_o     = held_result.parse_status;
  assign version_value_o    = held_result.version_value;
  assign timestamp_value_o  = held_result.timestamp_value;
  assign ext_length_value_o = held_result.ext_length_value;
  assign hash_alg_value_o   = held_result.hash_alg_value;
  assign sig_alg_value_o    = held_result.sig_alg_value;
  assign sig_length_value_o = held_result.sig_length_value;

  // status only carries meaning on the closing byte
  a_status_only_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !record_done_o |-> parse_status_o == ST_OK)
    else $error("status set on a byte that does not close the record");

  // a version byte opens a record, so later fields are still clear
  a_version_opens_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && field_kind_o == PH_VERSION |->
      field_offset_o == 16'd0 && timestamp_value_o == 64'd0 &&
      ext_length_value_o == 16'd0 && sig_length_value_o == 16'd0)
    else $error("version byte seen with stale record state");

  // one-byte fields never advance their offset
  a_single_byte_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (field_kind_o == PH_HASH || field_kind_o == PH_SIGALG) |->
      field_offset_o == 16'd0)
    else $error("one-byte field with non-zero offset");

endmodule

`default_nettype wire

// ----- hdl/sbp_field_tracker.sv -----
// field tracker: phase and offset state, scalar field decode, result build per byte
`default_nettype none

module sbp_field_tracker
  import sbp_pkg::*;
#(
  parameter int unsigned LogIdBytes = LOG_ID_BYTES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        item_last_i,
  output sbp_result_t      result_o
);

  localparam logic [15:0] LenLogId = 16'(LogIdBytes);

  sbp_phase_e  phase_q, phase_d;
  logic [15:0] offset_q, offset_d;
  logic [7:0]  version_q, version_d;
  logic [63:0] time_q, time_d;
  logic [15:0] ext_len_q, ext_len_d;
  logic [7:0]  hash_q, hash_d;
  logic [7:0]  sigalg_q, sigalg_d;
  logic [15:0] sig_len_q, sig_len_d;

  sbp_phase_e  kind;
  sbp_phase_e  next_phase;
  logic [15:0] field_len;
  logic        is_trail;
  logic        field_end;
  logic [15:0] next_offset;

  // decode the byte into the scalar field it belongs to
  always_comb begin
    version_d  = version_q;
    time_d     = time_q;
    ext_len_d  = ext_len_q;
    hash_d     = hash_q;
    sigalg_d   = sigalg_q;
    sig_len_d  = sig_len_q;
    kind       = phase_q;
    is_trail   = 1'b0;
    field_len  = 16'd0;
    next_phase = PH_TRAIL;
    unique case (phase_q)
      PH_VERSION: begin
        version_d  = data_byte_i;
        field_len  = LEN_VERSION;
        next_phase = PH_LOGID;
      end
      PH_LOGID: begin
        field_len  = LenLogId;
        next_phase = PH_TIME;
      end
      PH_TIME: begin
        time_d     = {time_q[55:0], data_byte_i};
        field_len  = LEN_TIME;
        next_phase = PH_EXTLEN;
      end
      PH_EXTLEN: begin
        ext_len_d  = {ext_len_q[7:0], data_byte_i};
        field_len  = LEN_EXTLEN;
        next_phase = (ext_len_d == 16'd0) ? PH_HASH : PH_EXT;
      end
      PH_EXT: begin
        field_len  = ext_len_q;
        next_phase = PH_HASH;
      end
      PH_HASH: begin
        hash_d     = data_byte_i;
        field_len  = LEN_HASH;
        next_phase = PH_SIGALG;
      end
      PH_SIGALG: begin
        sigalg_d   = data_byte_i;
        field_len  = LEN_SIGALG;
        next_phase = PH_SIGLEN;
      end
      PH_SIGLEN: begin
        sig_len_d  = {sig_len_q[7:0], data_byte_i};
        field_len  = LEN_SIGLEN;
        next_phase = (sig_len_d == 16'd0) ? PH_TRAIL : PH_SIG;
      end
      PH_SIG: begin
        field_len  = sig_len_q;
        next_phase = PH_TRAIL;
      end
      default: begin
        // trailing bytes, and any stray code, never end a field
        kind     = PH_TRAIL;
        is_trail = 1'b1;
      end
    endcase
  end

  // end of field and next offset
  always_comb begin
    field_end   = !is_trail && (({1'b0, offset_q} + 17'd1) >= {1'b0, field_len});
    next_offset = (offset_q == OFFSET_MAX) ? OFFSET_MAX : offset_q + 16'd1;
    if (field_end) begin
      phase_d  = next_phase;
      offset_d = 16'd0;
    end else begin
      phase_d  = kind;
      offset_d = next_offset;
    end
  end

  // result for this byte, with the decoded fields including it
  always_comb begin
    result_o.field_kind       = kind;
    result_o.byte_out         = data_byte_i;
    result_o.field_offset     = offset_q;
    result_o.record_done      = item_last_i;
    result_o.parse_status     = item_last_i ? status_for_next(phase_d) : ST_OK;
    result_o.version_value    = version_d;
    result_o.timestamp_value  = time_d;
    result_o.ext_length_value = ext_len_d;
    result_o.hash_alg_value   = hash_d;
    result_o.sig_alg_value    = sigalg_d;
    result_o.sig_length_value = sig_len_d;
  end

  // parser state, cleared again after the closing byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_VERSION;
      offset_q  <= 16'd0;
      version_q <= 8'd0;
      time_q    <= 64'd0;
      ext_len_q <= 16'd0;
      hash_q    <= 8'd0;
      sigalg_q  <= 8'd0;
      sig_len_q <= 16'd0;
    end else if (accept_i) begin
      if (item_last_i) begin
        phase_q   <= PH_VERSION;
        offset_q  <= 16'd0;
        version_q <= 8'd0;
        time_q    <= 64'd0;
        ext_len_q <= 16'd0;
        hash_q    <= 8'd0;
        sigalg_q  <= 8'd0;
        sig_len_q <= 16'd0;
      end else begin
        phase_q   <= phase_d;
        offset_q  <= offset_d;
        version_q <= version_d;
        time_q    <= time_d;
        ext_len_q <= ext_len_d;
        hash_q    <= hash_d;
        sigalg_q  <= sigalg_d;
        sig_len_q <= sig_len_d;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sbp_out_stage.sv -----
// result register: holds one byte result until downstream takes it
`default_nettype none

module sbp_out_stage
  import sbp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire sbp_result_t in_result_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output sbp_result_t      out_result_o
);

  logic        valid_q, valid_d;
  logic        load;
  sbp_result_t result_q;

  // stall upstream only while a held result is itself stalled
  assign in_stall_o = valid_q && out_stall_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load || (valid_q && out_stall_i);

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (load) begin
      result_q <= in_result_i;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_result_o = result_q;

endmodule

`default_nettype wire
